[sv/assert_macros.svh]
// Assertion macros shared by the statistics block RTL.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

[sv/ssamf_pkg.sv]
// Shared types and constants for the sample statistics block.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ssamf_pkg;

  localparam int unsigned SAMPLE_W = 15;

  // +/-50.0 in Q7.8
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 15'sd12800;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -15'sd12800;

  typedef enum logic [1:0] {
    KIND_MEAN  = 2'd0,
    KIND_MIN   = 2'd1,
    KIND_MAX   = 2'd2,
    KIND_ABOVE = 2'd3
  } kind_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic emit_mean;
    logic emit_min;
    logic walk_rd;
    logic flush;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic walk_end;
    logic rd_pend;
  } sts_t;

endpackage

[sv/sample_stats_above_mean_filter_core.sv]
// Sample statistics core: a sample without the last flag is taken while busy stays low.
// The closing sample starts a burst; busy stays high through the one-bit-per-cycle mean
// divider, the one-entry-per-cycle buffer walk and the closing flush. Results: mean,
// min, max, then each sample above the mean.
// Each result shows for one cycle on valid_o; results cannot be stalled.
// Asynchronous active-low reset clears the count, sum, min, max and drop flag.
`timescale 1ns / 1ps

module sample_stats_above_mean_filter_core import ssamf_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       last_sample_i,
  output logic                       busy,
  output logic                       valid_o,
  output logic [1:0]                 kind_o,
  output logic signed [SAMPLE_W-1:0] value_o,
  output logic                       dropped_o,
  output logic                       last_result_o
);

  cmd_t cmd;
  sts_t sts;

  ssamf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .last_sample_i(last_sample_i),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .busy_o       (busy)
  );

  ssamf_dp #(
    .MaxSamples(MAX_SAMPLES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .sample_i     (sample_i),
    .valid_o      (valid_o),
    .kind_o       (kind_o),
    .value_o      (value_o),
    .dropped_o    (dropped_o),
    .last_result_o(last_result_o)
  );

endmodule

[sv/ssamf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ssamf_ram #(
  parameter int unsigned Width = 15,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/ssamf_ctrl.sv]
// Sequencer of the sample statistics block: load, divide, emit, buffer walk, flush.
// Depends on ssamf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssamf_ctrl import ssamf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic last_sample_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREP  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_MEAN  = 7'b0001000,
    S_MIN   = 7'b0010000,
    S_WALK  = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (last_sample_i) state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_MEAN;
        else cmd_o.div_step = 1'b1;
      end
      S_MEAN: begin
        cmd_o.emit_mean = 1'b1;
        state_d         = S_MIN;
      end
      S_MIN: begin
        cmd_o.emit_min = 1'b1;
        state_d        = S_WALK;
      end
      S_WALK: begin
        // keep issuing reads, then let the last read data drain
        if (!sts_i.walk_end) cmd_o.walk_rd = 1'b1;
        else if (!sts_i.rd_pend) state_d = S_FLUSH;
      end
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  `ASSERT_CLK(a_last_item_busy, start_i && !busy_o && last_sample_i |=> busy_o,
              "closing item did not start a burst")

endmodule

[sv/ssamf_dp.sv]
// Datapath: saturation, running sum/min/max, sample buffer, bit-serial mean
// divider, above-mean test and result register. Depends on ssamf_pkg,
// ssamf_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssamf_dp import ssamf_pkg::*; #(
  parameter int unsigned MaxSamples = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output sts_t                       sts_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       valid_o,
  output logic [1:0]                 kind_o,
  output logic signed [SAMPLE_W-1:0] value_o,
  output logic                       dropped_o,
  output logic                       last_result_o
);

  localparam int unsigned CNT_W  = $clog2(MaxSamples + 1);
  localparam int unsigned IDX_W  = (MaxSamples > 1) ? $clog2(MaxSamples) : 1;
  // |sum| < 2^14 * 2^clog2(MaxSamples)
  localparam int unsigned SUM_W  = SAMPLE_W + $clog2(MaxSamples);
  localparam int unsigned DIV_W  = SUM_W - 1;
  localparam int unsigned DCNT_W = $clog2(DIV_W + 1);
  localparam int unsigned PROD_W = SAMPLE_W + CNT_W + 1;

  // ---- load side -------------------------------------------------------
  logic signed [SAMPLE_W-1:0] s_sat;
  logic [CNT_W-1:0]           count_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic signed [SAMPLE_W-1:0] min_q, max_q;
  logic                       ovf_q;
  logic                       full, store;

  always_comb begin
    priority if (sample_i > SAMPLE_MAX) s_sat = SAMPLE_MAX;
    else if (sample_i < SAMPLE_MIN) s_sat = SAMPLE_MIN;
    else s_sat = sample_i;
  end

  assign full  = (count_q == CNT_W'(MaxSamples));
  assign store = cmd_i.load && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      min_q   <= '0;
      max_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.flush) begin
      count_q <= '0;
      sum_q   <= '0;
      min_q   <= '0;
      max_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.load) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        count_q <= count_q + 1'b1;
        sum_q   <= sum_q + SUM_W'(s_sat);
        if (count_q == '0 || s_sat < min_q) min_q <= s_sat;
        if (count_q == '0 || s_sat > max_q) max_q <= s_sat;
      end
    end
  end

  // ---- sample buffer ---------------------------------------------------
  logic [CNT_W-1:0]           idx_q;
  logic                       rd_vld_q;
  logic [SAMPLE_W-1:0]        rd_data;

  ssamf_ram #(
    .Width(SAMPLE_W),
    .Depth(MaxSamples)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (store),
    .waddr_i(count_q[IDX_W-1:0]),
    .wdata_i(s_sat),
    .re_i   (cmd_i.walk_rd),
    .raddr_i(idx_q[IDX_W-1:0]),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.walk_rd;
      if (cmd_i.flush) idx_q <= '0;
      else if (cmd_i.walk_rd) idx_q <= idx_q + 1'b1;
    end
  end

  // ---- restoring divider on |sum|, one quotient bit per cycle -----------
  logic [SUM_W-1:0]  sum_mag;
  logic              neg_q;
  logic [DIV_W-1:0]  quo_q;
  logic [CNT_W-1:0]  rem_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [CNT_W:0]    rem_sh, rem_sub;
  logic              ge;

  assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
  assign ge      = (rem_sh >= {1'b0, count_q});
  assign rem_sub = rem_sh - {1'b0, count_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q <= sum_q[SUM_W-1];
      quo_q <= sum_mag[DIV_W-1:0];
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= DCNT_W'(DIV_W);
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q - 1'b1;
    end
  end

  logic [SUM_W-1:0]    quo_ext, mean_full;
  logic [SAMPLE_W-1:0] mean_val;

  assign quo_ext   = SUM_W'(quo_q);
  assign mean_full = neg_q ? (~quo_ext + 1'b1) : quo_ext;
  assign mean_val  = mean_full[SAMPLE_W-1:0];

  // ---- above-mean test: sample * count > sum ---------------------------
  logic signed [SAMPLE_W-1:0] rd_sample;
  logic signed [CNT_W:0]      cnt_s;
  logic signed [PROD_W-1:0]   prod, sum_ext;
  logic                       hit;

  assign rd_sample = $signed(rd_data);
  assign cnt_s     = $signed({1'b0, count_q});
  assign prod      = PROD_W'(rd_sample) * PROD_W'(cnt_s);
  assign sum_ext   = PROD_W'(sum_q);
  assign hit       = rd_vld_q && (prod > sum_ext);

  // ---- result path -----------------------------------------------------
  // One result is held back so that the final one can carry the last flag.
  kind_e                      pend_kind_q;
  logic signed [SAMPLE_W-1:0] pend_val_q;
  logic                       valid_q, last_q, dropped_q;
  kind_e                      kind_q;
  logic signed [SAMPLE_W-1:0] value_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_min) begin
      pend_kind_q <= KIND_MAX;
      pend_val_q  <= max_q;
    end else if (hit) begin
      pend_kind_q <= KIND_ABOVE;
      pend_val_q  <= rd_sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit_mean | cmd_i.emit_min | hit | cmd_i.flush;
    end
  end

  always_ff @(posedge clk_i) begin
    dropped_q <= ovf_q;
    priority if (cmd_i.emit_mean) begin
      kind_q  <= KIND_MEAN;
      value_q <= mean_val;
      last_q  <= 1'b0;
    end else if (cmd_i.emit_min) begin
      kind_q  <= KIND_MIN;
      value_q <= min_q;
      last_q  <= 1'b0;
    end else if (hit) begin
      kind_q  <= pend_kind_q;
      value_q <= pend_val_q;
      last_q  <= 1'b0;
    end else if (cmd_i.flush) begin
      kind_q  <= pend_kind_q;
      value_q <= pend_val_q;
      last_q  <= 1'b1;
    end
  end

  assign valid_o       = valid_q;
  assign kind_o        = kind_q;
  assign value_o       = value_q;
  assign dropped_o     = dropped_q;
  assign last_result_o = last_q;

  assign sts_o.div_done = (dcnt_q == '0);
  assign sts_o.walk_end = (idx_q == count_q);
  assign sts_o.rd_pend  = rd_vld_q;

  `ASSERT_NEVER(a_count_bound, count_q > CNT_W'(MaxSamples),
                "sample count beyond buffer depth")
  `ASSERT_CLK(a_quiet_after_last, valid_q && last_q |=> !valid_q,
              "result emitted after closing result")

endmodule
